FILE: hw/rtl/y2rgb_pkg.sv
// shared types and constants of the yuyv to rgb888 converter
package y2rgb_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_PAIRS_PER_LINE  = 2'd0;
  localparam logic [1:0] CFG_LINES_PER_FRAME = 2'd1;

  // bt.601 coefficients, signed q2.14
  localparam logic signed [15:0] COEF_RED_V   = 16'sd22971;
  localparam logic signed [15:0] COEF_GREEN_U = 16'sd5638;
  localparam logic signed [15:0] COEF_GREEN_V = 16'sd11700;
  localparam logic signed [15:0] COEF_BLUE_U  = 16'sd29032;

  localparam int FRAC_BITS = 14;
  localparam int TERM_W    = 24;
  localparam int SUM_W     = 25;

  localparam logic [8:0] CHROMA_MID  = 9'd128;
  localparam logic [7:0] CHANNEL_MAX = 8'd255;

  localparam logic [11:0] PAIRS_MAX = 12'd2048;
  localparam logic [12:0] LINES_MAX = 13'd4096;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } yuyv_t;

  typedef struct packed {
    logic [7:0]  blue_first;
    logic [7:0]  green_first;
    logic [7:0]  red_first;
    logic [7:0]  blue_second;
    logic [7:0]  green_second;
    logic [7:0]  red_second;
    logic [11:0] dest_row;
    logic [10:0] dest_pair;
    logic        end_of_frame;
  } rgb_pair_t;

  // chroma products shared by both lanes
  typedef struct packed {
    logic signed [TERM_W-1:0] red;
    logic signed [TERM_W-1:0] green_u;
    logic signed [TERM_W-1:0] green_v;
    logic signed [TERM_W-1:0] blue;
  } chroma_terms_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [11:0] dest_row;
    logic [10:0] dest_pair;
    logic        end_of_frame;
  } position_t;

endpackage

FILE: hw/rtl/yuyv_to_rgb888_converter_top.sv
// top level of the yuyv to rgb888 converter: lanes, counters and output stage
//
// usage:
//   pixel channel: one yuyv macropixel (two lumas, shared cb/cr) per request,
//   valid/ready handshake. rgb channel: two rgb888 pixels per request plus the
//   bottom-up destination row, the pair column and an end of frame flag.
//   config port: cfg_write_enable with cfg_index 0 (pairs per line) or
//   1 (lines per frame) and cfg_data; write only while the block is idle.
//   pipeline: an accepted request passes the chroma multiply stage and then
//   the lane add/clamp stage before rgb_valid; each stage is one register.
//   throughput: one request per cycle unless stalled, two pixel lanes run side by side.
//   stall: all stages advance together; while rgb_valid is high and rgb_ready
//   is low the pipeline holds and pixel_ready is low. the output register is
//   the skid point, so a new request is taken in the same cycle the held
//   result leaves.
//   reset: rst (synchronous) clears the pipeline valids and the counters and
//   sets pairs per line to 320 and lines per frame to 480.
module yuyv_to_rgb888_converter_top
  import y2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  yuyv_t       pixel,
  output logic        rgb_valid,
  input  logic        rgb_ready,
  output rgb_pair_t   rgb
);

  logic          advance;
  logic          accept;
  position_t     position;
  chroma_terms_t terms;

  logic          s1_valid;
  logic [7:0]    s1_luma_first;
  logic [7:0]    s1_luma_second;
  position_t     s1_position;

  rgb_t          lane_first;
  rgb_t          lane_second;

  assign advance     = !rgb_valid || rgb_ready;
  assign pixel_ready = advance;
  assign accept      = pixel_valid && pixel_ready;

  y2rgb_position u_position (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .step             (accept),
    .position         (position)
  );

  y2rgb_chroma u_chroma (
    .clk         (clk),
    .enable      (advance),
    .chroma_blue (pixel.chroma_blue),
    .chroma_red  (pixel.chroma_red),
    .terms       (terms)
  );

  y2rgb_lane u_lane_first (
    .luma  (s1_luma_first),
    .terms (terms),
    .pixel (lane_first)
  );

  y2rgb_lane u_lane_second (
    .luma  (s1_luma_second),
    .terms (terms),
    .pixel (lane_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rgb_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pixel_valid;
      rgb_valid <= s1_valid;
    end
  end

  // register the lumas and position into the middle stage; merge both lanes with the position into the output register
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_luma_first    <= pixel.luma_first;
      s1_luma_second   <= pixel.luma_second;
      s1_position      <= position;
      rgb.blue_first   <= lane_first.blue;
      rgb.green_first  <= lane_first.green;
      rgb.red_first    <= lane_first.red;
      rgb.blue_second  <= lane_second.blue;
      rgb.green_second <= lane_second.green;
      rgb.red_second   <= lane_second.red;
      rgb.dest_row     <= s1_position.dest_row;
      rgb.dest_pair    <= s1_position.dest_pair;
      rgb.end_of_frame <= s1_position.end_of_frame;
    end
  end

  // the last pair of a frame always lands on the bottom destination row
  a_eof_row: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && rgb.end_of_frame |-> rgb.dest_row == 12'd0)
    else $error("end of frame with nonzero dest_row");

  // an accepted request reaches the middle stage
  a_accept_to_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request lost before middle stage");

  // a middle stage request moves to the output when the pipe advances
  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> rgb_valid)
    else $error("middle stage request lost before output");

  // a held result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && !rgb_ready |-> !accept)
    else $error("request accepted while output stalled");

endmodule

FILE: hw/rtl/y2rgb_chroma.sv
// chroma offset multiplies, registered once for both pixel lanes
module y2rgb_chroma
  import y2rgb_pkg::*;
(
  input  logic          clk,
  input  logic          enable,
  input  logic [7:0]    chroma_blue,
  input  logic [7:0]    chroma_red,
  output chroma_terms_t terms
);

  logic signed [8:0]        du;
  logic signed [8:0]        dv;
  logic signed [TERM_W-1:0] red_p;
  logic signed [TERM_W-1:0] green_u_p;
  logic signed [TERM_W-1:0] green_v_p;
  logic signed [TERM_W-1:0] blue_p;

  assign du = $signed({1'b0, chroma_blue} - CHROMA_MID);
  assign dv = $signed({1'b0, chroma_red} - CHROMA_MID);

  assign red_p     = TERM_W'(dv) * TERM_W'(COEF_RED_V);
  assign green_u_p = TERM_W'(du) * TERM_W'(COEF_GREEN_U);
  assign green_v_p = TERM_W'(dv) * TERM_W'(COEF_GREEN_V);
  assign blue_p    = TERM_W'(du) * TERM_W'(COEF_BLUE_U);

  always_ff @(posedge clk) begin
    if (enable) begin
      terms.red     <= red_p;
      terms.green_u <= green_u_p;
      terms.green_v <= green_v_p;
      terms.blue    <= blue_p;
    end
  end

endmodule

FILE: hw/rtl/y2rgb_lane.sv
// one pixel lane: luma plus chroma terms, truncate and clamp
module y2rgb_lane
  import y2rgb_pkg::*;
(
  input  logic [7:0]    luma,
  input  chroma_terms_t terms,
  output rgb_t          pixel
);

  function automatic logic [7:0] to_channel(input logic signed [SUM_W-1:0] sum);
    logic [SUM_W-FRAC_BITS-1:0] whole;
    whole = sum[SUM_W-1:FRAC_BITS];
    if (sum <= 0) begin
      return 8'd0;
    end else if (whole > {{(SUM_W-FRAC_BITS-8){1'b0}}, CHANNEL_MAX}) begin
      return CHANNEL_MAX;
    end else begin
      return whole[7:0];
    end
  endfunction

  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] red_sum;
  logic signed [SUM_W-1:0] green_sum;
  logic signed [SUM_W-1:0] blue_sum;

  assign base = $signed({{(SUM_W-8-FRAC_BITS){1'b0}}, luma, {FRAC_BITS{1'b0}}});

  assign red_sum   = base + SUM_W'(terms.red);
  assign green_sum = base - SUM_W'(terms.green_u) - SUM_W'(terms.green_v);
  assign blue_sum  = base + SUM_W'(terms.blue);

  assign pixel.red   = to_channel(red_sum);
  assign pixel.green = to_channel(green_sum);
  assign pixel.blue  = to_channel(blue_sum);

endmodule

FILE: hw/rtl/y2rgb_position.sv
// line geometry registers and pair/line counters with bottom-up row
module y2rgb_position
  import y2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        step,
  output position_t   position
);

  logic [11:0] pairs_per_line;
  logic [12:0] lines_per_frame;
  logic [10:0] pair_column;
  logic [11:0] line_index;

  logic [10:0] pair_last;
  logic [11:0] line_last;
  logic        line_end;
  logic        line_past;

  // zero acts as one, above range acts as the maximum
  always_comb begin
    if (pairs_per_line == 12'd0) begin
      pair_last = 11'd0;
    end else if (pairs_per_line > PAIRS_MAX) begin
      pair_last = 11'(PAIRS_MAX - 12'd1);
    end else begin
      pair_last = 11'(pairs_per_line - 12'd1);
    end
    if (lines_per_frame == 13'd0) begin
      line_last = 12'd0;
    end else if (lines_per_frame > LINES_MAX) begin
      line_last = 12'(LINES_MAX - 13'd1);
    end else begin
      line_last = 12'(lines_per_frame - 13'd1);
    end
  end

  assign line_end  = pair_column >= pair_last;
  assign line_past = line_index >= line_last;

  assign position.dest_pair    = pair_column;
  assign position.end_of_frame = line_end && line_past;
  assign position.dest_row     = (line_index > line_last) ? 12'd0 : line_last - line_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_per_line  <= 12'd320;
      lines_per_frame <= 13'd480;
      pair_column     <= 11'd0;
      line_index      <= 12'd0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_PAIRS_PER_LINE:  pairs_per_line  <= cfg_data[11:0];
          CFG_LINES_PER_FRAME: lines_per_frame <= cfg_data;
          default: ;
        endcase
      end
      if (step) begin
        if (line_end) begin
          pair_column <= 11'd0;
          line_index  <= line_past ? 12'd0 : line_index + 12'd1;
        end else begin
          pair_column <= pair_column + 11'd1;
        end
      end
    end
  end

endmodule
